// ----- rtl/nst_pkg.sv -----
package nst_pkg;

  // Field and register widths.
  localparam int OCTAVE_W       = 4;
  localparam int SEMITONE_W     = 4;
  localparam int BEATS_W        = 8;
  localparam int SAMPLE_W       = 16;
  localparam int RATE_W         = 18;
  localparam int VOLUME_W       = 15;
  localparam int BEAT_SAMPLES_W = 24;
  localparam int CFG_DATA_W     = 24;
  localparam int CFG_INDEX_W    = 2;
  localparam int COUNT_W        = 32;

  // Phase accumulator and sine table geometry.
  localparam int PHASE_BITS  = 32;
  localparam int SINE_DEPTH  = 1024;
  localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
  localparam int QLOW_W      = SINE_IDX_W - 2;
  localparam int QTAB_N      = SINE_DEPTH / 4 + 1;
  localparam int QIDX_W      = $clog2(QTAB_N);
  localparam int MAG_W       = 15;
  localparam int PROD_W      = MAG_W + VOLUME_W + 1;
  localparam int ROUND_HALF  = 16384;

  // Frequency path: Q16.16 table, shifted by octave, then divided with
  // PHASE_BITS-16 extra fraction bits.
  localparam int FREQ_TAB_W  = 26;
  localparam int OCT_SPAN    = 1 << OCTAVE_W;
  localparam int FREQ_WIDE_W = FREQ_TAB_W + OCT_SPAN - 1;
  localparam int FREQ_W      = FREQ_WIDE_W - 4;
  localparam int FRAC_BITS   = PHASE_BITS - 16;
  localparam int DIVIDEND_W  = FREQ_W + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] MAG_MAX     = 64'd32767;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SAMPLE_RATE  = 2'd0,
    REG_VOLUME       = 2'd1,
    REG_BEAT_SAMPLES = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_READ,
    B_MUL,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic [RATE_W-1:0]         sample_rate;
    logic [VOLUME_W-1:0]       volume;
    logic [BEAT_SAMPLES_W-1:0] beat_samples;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [FREQ_W-1:0]   freq;
    logic [BEATS_W-1:0]  beats;
  } q_item_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [RATE_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [PHASE_BITS-1:0] quotient;
  } div_rsp_t;

  // Octave-4 note frequencies in Q16.16 Hz, C up to D# of the next octave.
  localparam logic [FREQ_TAB_W-1:0] SEMI_HZ_Q16 [0:15] = '{
    26'd17145893, 26'd18165441, 26'd19245615, 26'd20390018,
    26'd21602472, 26'd22887021, 26'd24247954, 26'd25689813,
    26'd27217409, 26'd28835840, 26'd30550508, 26'd32367136,
    26'd34291785, 26'd36330882, 26'd38491229, 26'd40780036
  };

  typedef logic [MAG_W-1:0] qsin_tab_t [0:QTAB_N-1];

  // Quarter-wave sine magnitudes in Q0.15, built at elaboration from a
  // Q30 Taylor series up to x^9.
  function automatic qsin_tab_t build_qsin();
    qsin_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] mag;
    for (int j = 0; j < QTAB_N; j++) begin
      x   = (64'(4 * j) * HALF_PI_Q30) / 64'(SINE_DEPTH);
      x2  = (x * x) >> 30;
      t   = ONE_Q30 - x2 / 64'd72;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s   = (x * t) >> 30;
      mag = (s * MAG_MAX + (ONE_Q30 >> 1)) >> 30;
      if (mag > MAG_MAX) begin
        mag = MAG_MAX;
      end
      tab[j] = MAG_W'(mag);
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN = build_qsin();

endpackage

// ----- rtl/nst_in_if.sv -----
interface nst_in_if import nst_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [OCTAVE_W-1:0]   octave;
  logic [SEMITONE_W-1:0] semitone;
  logic [BEATS_W-1:0]    duration_beats;

  modport source (output valid, command, octave, semitone, duration_beats, input ready);
  modport sink (input valid, command, octave, semitone, duration_beats, output ready);
endinterface

// ----- rtl/nst_out_if.sv -----
interface nst_out_if import nst_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_of_note;

  modport source (output valid, sample, last_of_note, input ready);
  modport sink (input valid, sample, last_of_note, output ready);
endinterface

// ----- rtl/note_sine_tone_generator.sv -----
// Tick request: a sample passes queue pop, sine table read, volume multiply and
// output register in turn; a new request waits until the sample is registered,
// which stalls while ready is low. Load request: the bit-serial phase increment
// divider holds the datapath, one quotient bit per cycle; a load gives no sample.
// A two-entry request queue lets intake run ahead of the sample datapath.
// Synchronous active-high reset clears the note state and restores defaults.
module note_sine_tone_generator import nst_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  nst_in_if.sink                 notes,
  nst_out_if.source              samples,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t     cfg;
  logic     q_valid;
  q_item_t  q_item;
  logic     q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_rate  <= RATE_W'(44100);
      cfg.volume       <= VOLUME_W'(16000);
      cfg.beat_samples <= BEAT_SAMPLES_W'(22050);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_RATE:  cfg.sample_rate  <= cfg_data[RATE_W-1:0];
        REG_VOLUME:       cfg.volume       <= cfg_data[VOLUME_W-1:0];
        REG_BEAT_SAMPLES: cfg.beat_samples <= cfg_data[BEAT_SAMPLES_W-1:0];
        default: ;
      endcase
    end
  end

  nst_front u_front (
    .clk     (clk),
    .rst     (rst),
    .notes   (notes),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  nst_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  nst_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .samples (samples)
  );

endmodule

// ----- rtl/nst_front.sv -----
module nst_front import nst_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  nst_in_if.sink  notes,
  output logic    q_valid,
  output q_item_t q_item,
  input  logic    q_pop
);

  q_item_t            slots [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               pop;
  logic [FREQ_WIDE_W-1:0] freq_wide;
  q_item_t            entry;

  assign notes.ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push        = notes.valid && notes.ready;
  assign q_valid     = (count != '0);
  assign pop         = q_pop && q_valid;
  assign q_item      = slots[rd_ptr];

  // Shifting left by the octave and then right by four gives the same floor
  // as a right shift for the low octaves.
  always_comb begin
    freq_wide   = FREQ_WIDE_W'(SEMI_HZ_Q16[notes.semitone]) << notes.octave;
    entry.kind  = (notes.command == CMD_TICK) ? CMD_TICK : CMD_LOAD;
    entry.freq  = freq_wide[FREQ_WIDE_W-1:4];
    entry.beats = notes.duration_beats;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  // The depth is a power of two, so the pointers wrap on their own.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/nst_div.sv -----
module nst_div import nst_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVIDEND_W-1:0] dvd;
  logic [RATE_W-1:0]     dvs;
  logic [RATE_W-1:0]     rem;
  logic [PHASE_BITS-1:0] quo;
  logic                  done;
  logic [RATE_W:0]       trial;
  logic                  fits;

  // One restoring step per cycle, most significant dividend bit first.
  // Only the low PHASE_BITS of the quotient are kept.
  always_comb begin
    trial = {rem, dvd[DIVIDEND_W-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= fits ? RATE_W'(trial - {1'b0, dvs}) : trial[RATE_W-1:0];
      quo <= {quo[PHASE_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/nst_back.sv -----
module nst_back import nst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  q_item_t   q_item,
  output logic      q_pop,
  output div_req_t  div_req,
  input  div_rsp_t  div_rsp,
  nst_out_if.source samples
);

  back_state_t state;
  back_state_t state_next;

  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_inc;
  logic [COUNT_W-1:0]    remaining;
  logic                  active;

  logic [QIDX_W-1:0]     rd_idx;
  logic                  rd_neg;
  logic                  rd_last;
  logic [MAG_W-1:0]      qmag;
  logic [SAMPLE_W-1:0]   scaled;
  logic [PROD_W-1:0]     prod;

  logic                  out_valid;
  logic [SAMPLE_W-1:0]   out_sample;
  logic                  out_last;

  logic                  take_load;
  logic                  take_tick;
  logic                  emit;

  logic [SINE_IDX_W-1:0] k;
  logic [QIDX_W-1:0]     k_low;
  logic [QIDX_W-1:0]     t_idx;
  logic [COUNT_W-1:0]    note_len;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_valid && q_item.kind == CMD_LOAD) begin
          state_next = B_DIV;
        end else if (q_valid && active) begin
          state_next = B_READ;
        end
      end
      B_DIV: begin
        if (div_rsp.done) begin
          state_next = B_IDLE;
        end
      end
      B_READ: state_next = B_MUL;
      B_MUL:  state_next = B_EMIT;
      B_EMIT: begin
        if (!out_valid || samples.ready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Control outputs. A tick that finds no active note is dropped here.
  always_comb begin
    q_pop     = 1'b0;
    take_load = 1'b0;
    take_tick = 1'b0;
    emit      = 1'b0;
    case (state)
      B_IDLE: begin
        q_pop     = q_valid;
        take_load = q_valid && (q_item.kind == CMD_LOAD);
        take_tick = q_valid && (q_item.kind == CMD_TICK) && active;
      end
      B_EMIT: emit = !out_valid || samples.ready;
      default: ;
    endcase
  end

  assign div_req.start    = take_load;
  assign div_req.dividend = {q_item.freq, FRAC_BITS'(0)};
  assign div_req.divisor  = (cfg.sample_rate == '0) ? RATE_W'(1) : cfg.sample_rate;

  // Quarter-wave folding of the top phase bits onto the stored quadrant.
  always_comb begin
    k        = phase[PHASE_BITS-1 -: SINE_IDX_W];
    k_low    = QIDX_W'(k[QLOW_W-1:0]);
    t_idx    = k[QLOW_W] ? QIDX_W'(QTAB_N - 1) - k_low : k_low;
    note_len = COUNT_W'(q_item.beats) * COUNT_W'(cfg.beat_samples);
    prod     = PROD_W'(qmag) * PROD_W'(cfg.volume) + PROD_W'(ROUND_HALF);
  end

  assign samples.valid        = out_valid;
  assign samples.sample       = out_sample;
  assign samples.last_of_note = out_last;

  always_ff @(posedge clk) begin
    if (take_tick) begin
      rd_idx  <= t_idx;
      rd_neg  <= k[QLOW_W+1];
      rd_last <= (remaining == COUNT_W'(1));
    end
    if (state == B_READ) begin
      qmag <= QSIN[rd_idx];
    end
    if (state == B_MUL) begin
      scaled <= prod[PROD_W-1 -: SAMPLE_W];
    end
    if (emit) begin
      out_sample <= rd_neg ? -scaled : scaled;
      out_last   <= rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      phase     <= '0;
      phase_inc <= '0;
      remaining <= '0;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take_load) begin
        phase     <= '0;
        remaining <= note_len;
        active    <= (note_len != '0);
      end else if (take_tick) begin
        phase     <= phase + phase_inc;
        remaining <= remaining - 1'b1;
        active    <= (remaining != COUNT_W'(1));
      end
      if (state == B_DIV && div_rsp.done) begin
        phase_inc <= div_rsp.quotient;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (samples.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- tb/sv/note_sine_tone_generator_tb.sv -----
module note_sine_tone_generator_tb;
  import nst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_note;
  } tone_sample_t;

  // Tracks the synthesizer state and queues the samples each request must produce.
  class tone_predictor;
    logic [RATE_W-1:0]         rate;
    logic [VOLUME_W-1:0]       vol;
    logic [BEAT_SAMPLES_W-1:0] beat_len;
    logic [31:0]               phase;
    logic [31:0]               step;
    logic [31:0]               left;
    bit                        playing;
    tone_sample_t              expected_samples[$];
    int                        errors;
    logic [63:0]               octave4_hz_q16[16];

    function new();
      octave4_hz_q16 = '{
        64'd17145893, 64'd18165441, 64'd19245615, 64'd20390018,
        64'd21602472, 64'd22887021, 64'd24247954, 64'd25689813,
        64'd27217409, 64'd28835840, 64'd30550508, 64'd32367136,
        64'd34291785, 64'd36330882, 64'd38491229, 64'd40780036
      };
      rate     = 18'd44100;
      vol      = 15'd16000;
      beat_len = 24'd22050;
      phase    = '0;
      step     = '0;
      left     = '0;
      playing  = 1'b0;
      errors   = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_SAMPLE_RATE:  rate = value[RATE_W-1:0];
        REG_VOLUME:       vol = value[VOLUME_W-1:0];
        REG_BEAT_SAMPLES: beat_len = value[BEAT_SAMPLES_W-1:0];
        default: ;
      endcase
    endfunction

    // Signed Q1.15 sine of table slot k, folded from the first quadrant.
    function int unit_sine(logic [9:0] k);
      logic [63:0] one;
      logic [63:0] t;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] mag;
      one = 64'd1073741824;
      t = k[8] ? 64'd1024 - 64'({k[7:0], 2'b00}) : 64'({k[7:0], 2'b00});
      x = (t * 64'd1686629713) / 64'd1024;
      x2 = (x * x) >> 30;
      p = one - x2 / 64'd72;
      p = one - ((x2 * p) >> 30) / 64'd42;
      p = one - ((x2 * p) >> 30) / 64'd20;
      p = one - ((x2 * p) >> 30) / 64'd6;
      s = (x * p) >> 30;
      mag = (s * 64'd32767 + (one >> 1)) >> 30;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      return k[9] ? -int'(mag) : int'(mag);
    endfunction

    function void take_request(cmd_kind_t cmd, logic [OCTAVE_W-1:0] oct,
                               logic [SEMITONE_W-1:0] semi, logic [BEATS_W-1:0] beats);
      logic [63:0]  freq;
      logic [63:0]  div;
      int           s;
      int           mag;
      tone_sample_t res;
      if (cmd == CMD_LOAD) begin
        freq = octave4_hz_q16[semi];
        if (oct >= 4) begin
          freq = freq << (oct - 4);
        end else begin
          freq = freq >> (4 - oct);
        end
        div = (rate == '0) ? 64'd1 : 64'(rate);
        step = 32'((freq << 16) / div);
        phase = '0;
        left = 32'(64'(beats) * 64'(beat_len));
        playing = (left != '0);
      end else if (playing) begin
        s = unit_sine(phase[31:22]);
        mag = ((s < 0 ? -s : s) * int'(vol) + 16384) >>> 15;
        phase = phase + step;
        left = left - 32'd1;
        playing = (left != '0);
        res.sample = SAMPLE_W'(s < 0 ? -mag : mag);
        res.last_of_note = !playing;
        expected_samples.insert(expected_samples.size(), res);
      end
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] sample, logic last_of_note);
      tone_sample_t want;
      if (expected_samples.size() == 0) begin
        $error("sample %0d arrived with no request waiting for it", sample);
        errors++;
      end else begin
        want = expected_samples.pop_front();
        if (sample !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, sample);
          errors++;
        end
        if (last_of_note !== want.last_of_note) begin
          $error("last_of_note: expected %0b, got %0b", want.last_of_note, last_of_note);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  bit                     in_burst;
  bit                     out_burst;
  tone_predictor          tones;

  nst_in_if  notes ();
  nst_out_if samples ();

  note_sine_tone_generator dut (
    .clk       (clk),
    .rst       (rst),
    .notes     (notes),
    .samples   (samples),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_request(cmd_kind_t cmd, logic [OCTAVE_W-1:0] oct,
                              logic [SEMITONE_W-1:0] semi, logic [BEATS_W-1:0] beats);
    int gap;
    if ($urandom_range(0, 63) == 0) begin
      in_burst = !in_burst;
    end
    gap = in_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      notes.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    notes.valid          <= 1'b1;
    notes.command        <= cmd;
    notes.octave         <= oct;
    notes.semitone       <= semi;
    notes.duration_beats <= beats;
    @(posedge clk);
    while (!notes.ready) @(posedge clk);
    tones.take_request(cmd, oct, semi, beats);
  endtask

  task automatic send_tick();
    send_request(CMD_TICK, OCTAVE_W'($urandom), SEMITONE_W'($urandom), BEATS_W'($urandom));
  endtask

  // Registers change only once the block has gone quiet; a load still in the
  // divider produces no sample, so a fixed settle time follows the drain.
  task automatic apply_settings(logic [RATE_W-1:0] rate, logic [VOLUME_W-1:0] vol,
                                logic [BEAT_SAMPLES_W-1:0] beat_len);
    notes.valid <= 1'b0;
    @(posedge clk);
    while (tones.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SAMPLE_RATE;
    cfg_data  <= CFG_DATA_W'(rate);
    @(posedge clk);
    tones.set_register(REG_SAMPLE_RATE, CFG_DATA_W'(rate));
    cfg_index <= REG_VOLUME;
    cfg_data  <= CFG_DATA_W'(vol);
    @(posedge clk);
    tones.set_register(REG_VOLUME, CFG_DATA_W'(vol));
    cfg_index <= REG_BEAT_SAMPLES;
    cfg_data  <= CFG_DATA_W'(beat_len);
    @(posedge clk);
    tones.set_register(REG_BEAT_SAMPLES, CFG_DATA_W'(beat_len));
    cfg_we <= 1'b0;
  endtask

  // Mostly whole notes: a load followed by about as many ticks as the note
  // lasts, sometimes cut short by the next load, plus a few stray ticks.
  task automatic play_notes(int n_items);
    int          sent;
    int          pick;
    int          total;
    int          ticks;
    logic [7:0]  beats;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 19) == 0) begin
        send_tick();
        sent++;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          beats = 8'd0;
        end else if (pick < 8) begin
          beats = 8'($urandom_range(1, 6));
        end else begin
          beats = 8'($urandom_range(0, 255));
        end
        send_request(CMD_LOAD, OCTAVE_W'($urandom), SEMITONE_W'($urandom), beats);
        total = int'(beats) * int'(tones.beat_len);
        ticks = (total > 24) ? $urandom_range(1, 24) : total + $urandom_range(0, 2);
        repeat (ticks) send_tick();
        sent += 1 + ticks;
      end
    end
  endtask

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (notes.valid && notes.ready) || (samples.valid && samples.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("note_sine_tone_generator: mismatch");
    $finish;
  end

  initial begin
    int gap;
    out_burst = 1'b0;
    samples.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) begin
        out_burst = !out_burst;
      end
      gap = out_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        samples.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      samples.ready <= 1'b1;
      @(posedge clk);
      while (!samples.valid) @(posedge clk);
      tones.check_sample(samples.sample, samples.last_of_note);
    end
  end

  initial begin
    tones = new();
    in_burst = 1'b0;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_SAMPLE_RATE;
    cfg_data             <= '0;
    notes.valid          <= 1'b0;
    notes.command        <= CMD_LOAD;
    notes.octave         <= '0;
    notes.semitone       <= '0;
    notes.duration_beats <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: idle ticks, a zero-length note, and notes that are
    // replaced while still playing, including octave and semitone past the scale.
    send_tick();
    send_request(CMD_LOAD, 4'd4, 4'd9, 8'd0);
    send_tick();
    send_request(CMD_LOAD, 4'd0, 4'd0, 8'd255);
    repeat (3) send_tick();
    send_request(CMD_LOAD, 4'd15, 4'd15, 8'd1);
    repeat (2) send_tick();

    // A zero sample rate divides by one; one-sample beats show the last flag.
    apply_settings(18'd0, 15'd32767, 24'd1);
    send_request(CMD_LOAD, 4'd9, 4'd11, 8'd1);
    repeat (2) send_tick();
    send_request(CMD_LOAD, 4'd4, 4'd9, 8'd3);
    repeat (3) send_tick();

    // Zero beat length leaves the note idle at once.
    apply_settings(18'h3FFFF, 15'd0, 24'd0);
    send_request(CMD_LOAD, 4'd5, 4'd12, 8'd255);
    send_tick();

    apply_settings(18'd1000, 15'd1, 24'hFFFFFF);
    send_request(CMD_LOAD, 4'd10, 4'd3, 8'd255);
    repeat (3) send_tick();

    // Volume takes effect on the note that is still playing.
    apply_settings(18'd1000, 15'd20000, 24'hFFFFFF);
    repeat (2) send_tick();
    send_request(CMD_LOAD, 4'd4, 4'd9, 8'd0);
    send_tick();

    apply_settings(18'd44100, 15'd16000, 24'd3);
    play_notes(235);
    apply_settings(18'd192000, 15'd32767, 24'd1);
    play_notes(235);
    apply_settings(18'd1000, 15'd0, 24'd5);
    play_notes(235);
    apply_settings(18'd0, VOLUME_W'($urandom), 24'd2);
    play_notes(235);
    apply_settings(18'h3FFFF, 15'd32767, 24'd8);
    play_notes(235);
    apply_settings(RATE_W'($urandom_range(1000, 192000)), VOLUME_W'($urandom),
                   BEAT_SAMPLES_W'($urandom_range(1, 8)));
    play_notes(235);
    apply_settings(18'd48000, 15'd1, 24'd4);
    play_notes(235);

    notes.valid <= 1'b0;
    @(posedge clk);
    while (tones.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tones.errors == 0 && tones.pending() == 0) begin
      $display("note_sine_tone_generator: match");
    end else begin
      $display("note_sine_tone_generator: mismatch");
    end
    $finish;
  end

endmodule
